FILE: rtl/stsg_pkg.sv
// Shared constants, types and the quarter-wave sine table for the sine tone generator.
`timescale 1ns / 1ps

package stsg_pkg;

    // Sample clock and phase format
    localparam longint unsigned SAMPLE_RATE = 64'd44100;
    localparam int PHASE_BITS = 32;
    localparam int TABLE_BITS = 10;

    // Field widths
    localparam int FREQ_W   = 15;
    localparam int AMP_W    = 16;
    localparam int FS_W     = 15;
    localparam int SAMPLE_W = 16;
    localparam int AMP_FRAC = 15;

    localparam logic [FS_W-1:0] FS_RESET = 15'h7FFF;

    // Phase increment: inc = freq*K + round((freq*R) / SAMPLE_RATE)
    localparam longint unsigned INC_K   = (64'd1 << PHASE_BITS) / SAMPLE_RATE;
    localparam longint unsigned INC_R   = (64'd1 << PHASE_BITS) - INC_K * SAMPLE_RATE;
    localparam longint unsigned HALF_SR = SAMPLE_RATE / 64'd2;
    localparam int SR_W = $clog2(SAMPLE_RATE + 64'd1);
    localparam int X_W  = FREQ_W + SR_W;

    // Reciprocal for the division by SAMPLE_RATE; estimate is low by at most one
    localparam int RECIP_SH = X_W;
    localparam longint unsigned RECIP_M = (64'd1 << RECIP_SH) / SAMPLE_RATE;
    localparam int M_W  = $clog2(RECIP_M + 64'd1);
    localparam int Q_W  = M_W;
    localparam int RP_W = X_W + M_W;
    localparam int REM_W = SR_W + 1;

    // Sine table
    localparam int QTR_BITS = TABLE_BITS - 2;
    localparam int QTR_SIZE = 1 << QTR_BITS;
    localparam int SIN_FRAC = 30;
    localparam int SIN_W    = SIN_FRAC + 1;

    // Scaling datapath
    localparam int AF_W   = AMP_W + FS_W;
    localparam int PROD_W = SIN_W + AF_W;
    localparam int MAG_SH = SIN_FRAC + AMP_FRAC;
    localparam int MAG_W  = PROD_W - MAG_SH;

    localparam int QUEUE_DEPTH = 2;

    localparam longint unsigned Q30_ONE = 64'd1 << SIN_FRAC;
    localparam longint unsigned SIN_A1  = 64'd1686629713;
    localparam longint unsigned SIN_A3  = 64'd693598669;
    localparam longint unsigned SIN_A5  = 64'd85569306;
    localparam longint unsigned SIN_A7  = 64'd5026995;
    localparam longint unsigned SIN_A9  = 64'd172272;

    typedef logic [SIN_W-1:0] t_qtab [QTR_SIZE];

    // One queued phase step
    typedef struct packed {
        logic [TABLE_BITS-1:0] idx;
        logic [AMP_W-1:0]      amp;
        logic                  last;
    } t_job;

    // sin(pi/2 * t), t in Q30, odd polynomial with truncated products
    function automatic logic [SIN_W-1:0] f_quarter_sine(input longint unsigned t);
        longint unsigned t2;
        longint unsigned p;
        t2 = (t * t) >> SIN_FRAC;
        p  = SIN_A9;
        p  = SIN_A7 - ((t2 * p) >> SIN_FRAC);
        p  = SIN_A5 - ((t2 * p) >> SIN_FRAC);
        p  = SIN_A3 - ((t2 * p) >> SIN_FRAC);
        p  = SIN_A1 - ((t2 * p) >> SIN_FRAC);
        p  = (t * p) >> SIN_FRAC;
        return (p > Q30_ONE) ? SIN_W'(Q30_ONE) : SIN_W'(p);
    endfunction

    function automatic t_qtab f_build_qtab();
        t_qtab tab;
        for (int k = 0; k < QTR_SIZE; k++) begin
            tab[k] = f_quarter_sine(longint'(k) << (SIN_FRAC - QTR_BITS));
        end
        return tab;
    endfunction

    localparam t_qtab QTAB = f_build_qtab();
    // Quarter-turn peak, the one point past the end of the table
    localparam logic [SIN_W-1:0] QTAB_TOP = f_quarter_sine(Q30_ONE);

endpackage

FILE: rtl/stsg_front.sv
// Front end: accepts ticks, derives the phase increment and advances the phase accumulator.
`timescale 1ns / 1ps

module stsg_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [stsg_pkg::FREQ_W-1:0]   i_freq,
    input  logic [stsg_pkg::AMP_W-1:0]    i_amp,
    input  logic                          i_last,
    output logic                          o_push,
    output stsg_pkg::t_job                o_job,
    input  logic                          i_full
);
    import stsg_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RECIP = 2'd1;
    localparam logic [1:0] ST_QMUL  = 2'd2;
    localparam logic [1:0] ST_STEP  = 2'd3;

    logic [1:0]            r_state;
    logic [PHASE_BITS-1:0] r_phase;
    logic [PHASE_BITS-1:0] n_phase;
    logic [PHASE_BITS-1:0] r_prod_k;
    logic [PHASE_BITS-1:0] r_base;
    logic [X_W-1:0]        r_x;
    logic [Q_W-1:0]        r_qest;
    logic [X_W-1:0]        r_qm;
    logic [AMP_W-1:0]      r_amp;
    logic                  r_last;

    logic [RP_W-1:0]       w_recip_prod;
    logic [X_W-1:0]        w_rem;
    logic                  w_carry;

    assign w_recip_prod = RP_W'(r_x) * RP_W'(RECIP_M);
    // quotient estimate may be one short; remainder tells
    assign w_rem   = r_x - r_qm;
    assign w_carry = (w_rem[REM_W-1:0] >= REM_W'(SAMPLE_RATE));
    assign n_phase = r_phase + r_base + PHASE_BITS'(w_carry);

    assign o_ready  = (r_state == ST_IDLE);
    assign o_push   = (r_state == ST_STEP) && !i_full;
    assign o_job.idx  = n_phase[PHASE_BITS-1 -: TABLE_BITS];
    assign o_job.amp  = r_amp;
    assign o_job.last = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_state <= ST_RECIP;
                    end
                end
                ST_RECIP: r_state <= ST_QMUL;
                ST_QMUL:  r_state <= ST_STEP;
                ST_STEP: begin
                    if (!i_full) begin
                        r_phase <= n_phase;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_prod_k <= PHASE_BITS'(i_freq) * PHASE_BITS'(INC_K);
            r_x      <= X_W'(i_freq) * X_W'(INC_R) + X_W'(HALF_SR);
            r_amp    <= i_amp;
            r_last   <= i_last;
        end
        if (r_state == ST_RECIP) begin
            r_qest <= w_recip_prod[RP_W-1:RECIP_SH];
        end
        if (r_state == ST_QMUL) begin
            r_qm   <= X_W'(r_qest) * X_W'(SAMPLE_RATE);
            r_base <= r_prod_k + PHASE_BITS'(r_qest);
        end
    end

    a_phase_moves_on_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_phase)) |-> $past(o_push))
        else $error("phase accumulator changed without a queue push");

endmodule

FILE: rtl/stsg_queue.sv
// Short queue of phase steps between the front end and the scaling back end.
`timescale 1ns / 1ps

module stsg_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  stsg_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output stsg_pkg::t_job o_job,
    output logic           o_empty
);
    import stsg_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into a full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from an empty queue");

endmodule

FILE: rtl/stsg_back.sv
// Back end: sine table lookup, amplitude and full-scale scaling, saturation, output register.
`timescale 1ns / 1ps

module stsg_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    output logic                          o_pop,
    input  stsg_pkg::t_job                i_job,
    input  logic [stsg_pkg::FS_W-1:0]     i_full_scale,
    output logic                          o_tvalid,
    input  logic                          i_tready,
    output logic [stsg_pkg::SAMPLE_W-1:0] o_sample,
    output logic                          o_last
);
    import stsg_pkg::*;

    // lookup stage
    logic              r_v1;
    logic [SIN_W-1:0]  r_sin;
    logic [AF_W-1:0]   r_af;
    logic              r_neg1;
    logic              r_last1;
    // product stage
    logic              r_v2;
    logic [PROD_W-1:0] r_prod;
    logic              r_neg2;
    logic              r_last2;
    // output register
    logic                r_vo;
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_last_o;

    logic w_en_o;
    logic w_en2;
    logic w_en1;
    logic [1:0]          w_quad;
    logic [QTR_BITS-1:0] w_qoff;
    logic [QTR_BITS:0]   w_qq;
    logic [SIN_W-1:0]    w_sin;
    logic [MAG_W-1:0]    w_mag;
    logic [FS_W-1:0]     w_sat;

    assign w_en_o = !r_vo || i_tready;
    assign w_en2  = !r_v2 || w_en_o;
    assign w_en1  = !r_v1 || w_en2;
    assign o_pop  = w_en1 && !i_empty;

    // quarter-wave symmetry: odd quadrants run the table backwards
    assign w_quad = i_job.idx[TABLE_BITS-1 -: 2];
    assign w_qoff = i_job.idx[QTR_BITS-1:0];
    assign w_qq   = w_quad[0] ? ((QTR_BITS+1)'(QTR_SIZE) - {1'b0, w_qoff}) : {1'b0, w_qoff};
    assign w_sin  = w_qq[QTR_BITS] ? QTAB_TOP : QTAB[w_qq[QTR_BITS-1:0]];

    assign w_mag = r_prod[PROD_W-1:MAG_SH];
    assign w_sat = (w_mag > MAG_W'(i_full_scale)) ? i_full_scale : w_mag[FS_W-1:0];

    assign o_tvalid = r_vo;
    assign o_sample = r_sample;
    assign o_last   = r_last_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= !i_empty;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en_o) begin
                r_vo <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_sin   <= w_sin;
            r_af    <= AF_W'(i_job.amp) * AF_W'(i_full_scale);
            r_neg1  <= w_quad[1];
            r_last1 <= i_job.last;
        end
        if (w_en2 && r_v1) begin
            r_prod  <= PROD_W'(r_sin) * PROD_W'(r_af);
            r_neg2  <= r_neg1;
            r_last2 <= r_last1;
        end
        if (w_en_o && r_v2) begin
            r_sample <= r_neg2 ? (SAMPLE_W'(0) - SAMPLE_W'(w_sat)) : SAMPLE_W'(w_sat);
            r_last_o <= r_last2;
        end
    end

    a_out_from_product_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_vo) |-> $past(r_v2))
        else $error("output became valid without an item in the product stage");

endmodule

FILE: rtl/sine_tone_sample_generator_core.sv
// Top level of the sine tone sample generator: ports, full-scale register, front/queue/back.
// Direct digital synthesis sine source. Each input item is one sample tick: the 32-bit
// phase accumulator advances by round(tone_freq * 2^32 / 44100) and the top 10 phase bits
// address a quarter-wave sine table (Q30, no interpolation). The sine is scaled by the
// Q1.15 amplitude and the full-scale register, truncated toward zero and saturated to
// plus or minus full scale; tlast is carried through. The phase is kept across segments,
// so tones join without a jump. Reset clears the phase and sets full scale to 32767.
// The front end takes one item at a time, none new until it is through: accept,
// reciprocal multiply, quotient multiply, then the remainder fix-up and phase step, which
// waits while the queue is full. This increment chain sets the rate. The back end is a
// three-register pipeline (table lookup with amplitude times full scale, the 31x31
// product, saturation into the output register). A two-entry queue sits between front
// and back, so the front keeps taking items while a result waits on the master side.
// Write full scale only while no item is in flight; the configuration port is always
// ready.
`timescale 1ns / 1ps

module sine_tone_sample_generator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // tick stream in
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [31:0]                   i_s_tdata,  // [14:0] tone_freq, [30:15] amplitude, [31] zero
    input  logic                          i_s_tlast,  // segment_end
    // sample stream out
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [stsg_pkg::SAMPLE_W-1:0] o_m_tdata,  // [15:0] sample, two's complement
    output logic                          o_m_tlast,  // last_sample
    // full-scale register write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [stsg_pkg::FS_W-1:0]     i_cfg_data
);
    import stsg_pkg::*;

    logic [FS_W-1:0] r_full_scale;

    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_empty;
    t_job w_front_job;
    t_job w_queue_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_scale <= FS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_full_scale <= i_cfg_data;
        end
    end

    // front: increment and phase step, one item at a time
    stsg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_freq  (i_s_tdata[FREQ_W-1:0]),
        .i_amp   (i_s_tdata[FREQ_W +: AMP_W]),
        .i_last  (i_s_tlast),
        .o_push  (w_push),
        .o_job   (w_front_job),
        .i_full  (w_full)
    );

    stsg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_queue_job),
        .o_empty (w_empty)
    );

    // back: lookup, scale, saturate, hold result for the sink
    stsg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (w_empty),
        .o_pop        (w_pop),
        .i_job        (w_queue_job),
        .i_full_scale (r_full_scale),
        .o_tvalid     (o_m_tvalid),
        .i_tready     (i_m_tready),
        .o_sample     (o_m_tdata),
        .o_last       (o_m_tlast)
    );

endmodule
